### rtl/stsg_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the
// sine tone sample generator. No dependencies.
package stsg_pkg;

  localparam int unsigned PHASE_BITS      = 32;
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned TONE_BITS       = 16;
  localparam int unsigned RATE_BITS       = 18;
  localparam int unsigned DEPTH_BITS      = 6;
  localparam int unsigned VOL_BITS        = 17;
  localparam int unsigned MAG_BITS        = 15;
  localparam int unsigned SLOT_BITS       = 32;
  localparam int unsigned PROD_BITS       = MAG_BITS + VOL_BITS;
  localparam int unsigned WIDE_BITS       = 2 * SLOT_BITS;
  // Q1.15 sine times Q0.16 volume carries this many fraction bits.
  localparam int unsigned SCALE_SHIFT     = MAG_BITS + VOL_BITS - 1;

  localparam int unsigned ROM_ENTRIES   = (2 ** SINE_TABLE_BITS) + 1;
  localparam int unsigned ROM_ADDR_BITS = $clog2(ROM_ENTRIES);

  localparam int unsigned APB_ADDR_BITS = 4;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic [RATE_BITS-1:0]  RATE_RESET  = RATE_BITS'(44100);
  localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = DEPTH_BITS'(16);
  localparam logic [VOL_BITS-1:0]   VOL_RESET   = VOL_BITS'(32768);
  localparam logic [VOL_BITS-1:0]   FULL_VOLUME = VOL_BITS'(65536);
  localparam logic [DEPTH_BITS-1:0] MIN_DEPTH   = DEPTH_BITS'(8);
  localparam logic [DEPTH_BITS-1:0] MAX_DEPTH   = DEPTH_BITS'(SLOT_BITS);

  // Register index, taken from paddr[3:2]; the last index holds no register.
  typedef enum logic [1:0] {
    REG_RATE   = 2'd0,
    REG_DEPTH  = 2'd1,
    REG_VOLUME = 2'd2,
    REG_SPARE  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [RATE_BITS-1:0]  rate_hz;
    logic [DEPTH_BITS-1:0] sample_bits;
    logic [VOL_BITS-1:0]   volume_gain;
  } cfg_t;

  typedef logic [MAG_BITS-1:0] sine_rom_t [ROM_ENTRIES];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  // Quarter sine in Q1.15 for step k of a quadrant, from the Taylor series of
  // the Q2.30 angle up to the fifteenth power.
  function automatic logic [MAG_BITS-1:0] quarter_sine(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint          acc;
    x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 0; n < 7; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if ((n & 1) == 0) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (longint'(1) << 30)) begin
      acc = longint'(1) << 30;
    end
    mag = ((64'(acc) * 64'd32767) + (64'd1 << 29)) >> 30;
    return MAG_BITS'(mag);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned i = 0; i < ROM_ENTRIES; i++) begin
      rom[i] = quarter_sine(i);
    end
    return rom;
  endfunction

endpackage

### rtl/stsg_cfg.sv
// APB register file for the sine tone sample generator: sample rate, depth
// and volume. Depends on stsg_pkg.
module stsg_cfg import stsg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output cfg_t                     cfg_o
);

  cfg_t       cfg_q;
  reg_idx_e   reg_idx;
  logic       wr_en;

  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_hz     <= RATE_RESET;
      cfg_q.sample_bits <= DEPTH_RESET;
      cfg_q.volume_gain <= VOL_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RATE:   cfg_q.rate_hz     <= pwdata[RATE_BITS-1:0];
        REG_DEPTH:  cfg_q.sample_bits <= pwdata[DEPTH_BITS-1:0];
        REG_VOLUME: cfg_q.volume_gain <= pwdata[VOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RATE:   prdata = APB_DATA_BITS'(cfg_q.rate_hz);
      REG_DEPTH:  prdata = APB_DATA_BITS'(cfg_q.sample_bits);
      REG_VOLUME: prdata = APB_DATA_BITS'(cfg_q.volume_gain);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/stsg_divider.sv
// Bit-serial restoring divider that forms the phase step
// tone * 2^PHASE_BITS / rate, one quotient bit per cycle. Depends on stsg_pkg.
module stsg_divider import stsg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TONE_BITS-1:0]  tone_i,
  input  logic [RATE_BITS-1:0]  rate_i,
  output logic                  done_o,
  output logic [PHASE_BITS-1:0] step_o
);

  localparam int unsigned Steps   = TONE_BITS + PHASE_BITS;
  localparam int unsigned CntBits = $clog2(Steps);

  logic [CntBits-1:0]    cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [RATE_BITS-1:0]  rem_q, rem_d;
  logic [RATE_BITS-1:0]  div_q;
  logic [TONE_BITS-1:0]  num_q;
  logic [PHASE_BITS-1:0] quo_q;
  logic [RATE_BITS:0]    trial;
  logic [RATE_BITS:0]    diff;
  logic                  ge;

  // The dividend is the tone followed by PHASE_BITS zeros; it enters MSB first.
  assign trial = {rem_q, num_q[TONE_BITS-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};
  assign rem_d = ge ? diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntBits'(1);
        if (cnt_q == CntBits'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Only the low PHASE_BITS quotient bits are kept: the step wraps a turn.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= rate_i;
      num_q <= tone_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[TONE_BITS-2:0], 1'b0};
      quo_q <= {quo_q[PHASE_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign step_o = quo_q;

endmodule

### rtl/stsg_sine_rom.sv
// Quarter-wave sine ROM, Q1.15 magnitudes for steps 0 to a full quadrant,
// with a registered read. Depends on stsg_pkg for the table builder.
module stsg_sine_rom import stsg_pkg::*; (
  input  logic                     clk_i,
  input  logic [ROM_ADDR_BITS-1:0] addr_i,
  output logic [MAG_BITS-1:0]      data_o
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [MAG_BITS-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SINE_ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

### rtl/stsg_multiplier.sv
// Serial shift-add multiplier for sine magnitude times volume, one volume bit
// per cycle, LSB first. Depends on stsg_pkg.
module stsg_multiplier import stsg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MAG_BITS-1:0]  mag_i,
  input  logic [VOL_BITS-1:0]  vol_i,
  output logic                 done_o,
  output logic [PROD_BITS-1:0] product_o
);

  localparam int unsigned CntBits = $clog2(VOL_BITS);

  logic [CntBits-1:0]   cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [MAG_BITS-1:0]  mcand_q;
  logic [PROD_BITS-1:0] prod_q;
  logic [MAG_BITS:0]    sum;

  // Upper MAG_BITS of the product register take the partial sums; the lower
  // VOL_BITS start as the multiplier and shift out as product bits shift in.
  assign sum = {1'b0, prod_q[PROD_BITS-1:VOL_BITS]}
             + (prod_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntBits'(1);
        if (cnt_q == CntBits'(VOL_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mag_i;
      prod_q  <= {{MAG_BITS{1'b0}}, vol_i};
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[VOL_BITS-1:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = prod_q;

endmodule

### rtl/sine_tone_sample_generator.sv
// Sine tone sample generator: a direct digital synthesis oscillator that
// turns tone ticks into left-aligned 32-bit I2S slot words for both channels.
// Depends on stsg_pkg, stsg_cfg, stsg_divider, stsg_sine_rom, stsg_multiplier.
//
// Each input word carries a tone frequency in hertz and stands for one sample
// tick. A zero tone is taken and gives no output word. A nonzero tone passes
// from acceptance to the output register through the bit-serial divider that
// forms tone * 2^32 / rate, one quotient bit per cycle, then the phase update,
// the registered sine ROM read, the multiplier load, the serial volume
// multiplier, scaling and packing.
// The next tone word is accepted in the cycle after its result is loaded, so
// no new word is taken while one is in flight or its output is stalled.
// Registers at byte addresses 0, 4 and 8 hold the sample rate, the sample
// depth and the Q0.16 volume; write them only while no tone is in flight.
module sine_tone_sample_generator import stsg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [15:0]              s_axis_tdata,  // [15:0] tone_hz
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [63:0]              m_axis_tdata,  // [31:0] left_word, [63:32] right_word
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ADDRESS,
    ST_MUL_START,
    ST_MULTIPLY,
    ST_PACK
  } state_e;

  localparam logic [ROM_ADDR_BITS-1:0] QUARTER_TURN = ROM_ADDR_BITS'(2 ** SINE_TABLE_BITS);

  state_e                 state_q;
  logic [PHASE_BITS-1:0]  phase_q;
  logic [SLOT_BITS-1:0]   mag_word_q;
  logic [SLOT_BITS-1:0]   out_word_q;
  logic                   out_valid_q;
  logic                   load_out;

  cfg_t                   cfg;
  logic [RATE_BITS-1:0]   rate_eff;
  logic [DEPTH_BITS-1:0]  depth_eff;
  logic [VOL_BITS-1:0]    vol_eff;
  logic [4:0]             peak_shift;
  logic [4:0]             align_shift;

  logic                   div_start;
  logic                   div_done;
  logic [PHASE_BITS-1:0]  div_step;
  logic [SINE_TABLE_BITS-1:0] step_k;
  logic [ROM_ADDR_BITS-1:0]   rom_addr;
  logic [MAG_BITS-1:0]    rom_data;
  logic                   mul_start;
  logic                   mul_done;
  logic [PROD_BITS-1:0]   mul_product;

  logic [WIDE_BITS-1:0]   prod_ext;
  logic [WIDE_BITS-1:0]   prod_diff;
  logic [SLOT_BITS-1:0]   scaled;
  logic [SLOT_BITS-1:0]   signed_word;
  logic [SLOT_BITS-1:0]   packed_word;

  assign pready = 1'b1;

  stsg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign rate_eff = (cfg.rate_hz == '0) ? RATE_BITS'(1) : cfg.rate_hz;
  assign depth_eff = (cfg.sample_bits < MIN_DEPTH) ? MIN_DEPTH :
                     (cfg.sample_bits > MAX_DEPTH) ? MAX_DEPTH : cfg.sample_bits;
  assign vol_eff = (cfg.volume_gain > FULL_VOLUME) ? FULL_VOLUME : cfg.volume_gain;
  assign peak_shift  = 5'(depth_eff - DEPTH_BITS'(1));
  assign align_shift = 5'(MAX_DEPTH - depth_eff);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign div_start = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0);
  assign mul_start = (state_q == ST_MUL_START);

  stsg_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .tone_i  (s_axis_tdata[TONE_BITS-1:0]),
    .rate_i  (rate_eff),
    .done_o  (div_done),
    .step_o  (div_step)
  );

  // Odd quadrants walk the table backward, so their step runs up to a full
  // quadrant, which is why the ROM holds one entry more than a power of two.
  assign step_k   = phase_q[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign rom_addr = phase_q[PHASE_BITS-2] ? (QUARTER_TURN - ROM_ADDR_BITS'(step_k))
                                          : ROM_ADDR_BITS'(step_k);

  stsg_sine_rom u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  stsg_multiplier u_multiplier (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mag_i     (rom_data),
    .vol_i     (vol_eff),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  // The peak 2^(d-1)-1 never needs a multiplier: x * peak = (x << (d-1)) - x.
  assign prod_ext  = WIDE_BITS'(mul_product);
  assign prod_diff = (prod_ext << peak_shift) - prod_ext;
  assign scaled    = prod_diff[SCALE_SHIFT +: SLOT_BITS];

  // The upper half turn is negative. Shifting left also drops the bits above
  // the sample depth, which is the mask.
  assign signed_word = phase_q[PHASE_BITS-1] ? (SLOT_BITS'(0) - mag_word_q) : mag_word_q;
  assign packed_word = signed_word << align_shift;

  assign load_out = (state_q == ST_PACK) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      mag_word_q  <= '0;
      out_word_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (div_start) begin
            state_q <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            phase_q <= phase_q + div_step;
            state_q <= ST_ADDRESS;
          end
        end
        ST_ADDRESS: begin
          state_q <= ST_MUL_START;
        end
        ST_MUL_START: begin
          state_q <= ST_MULTIPLY;
        end
        ST_MULTIPLY: begin
          if (mul_done) begin
            mag_word_q <= scaled;
            state_q    <= ST_PACK;
          end
        end
        ST_PACK: begin
          if (load_out) begin
            out_word_q <= packed_word;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_word_q, out_word_q};

endmodule

### rtl/stsg_checker.sv
// Port-level checks for the sine tone sample generator, bound to its top
// level. Depends on stsg_pkg and sine_tone_sample_generator.
module stsg_checker import stsg_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        pready
);

  // A stalled output word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed or dropped while stalled");

  // Both channels always carry the same sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:0] == m_axis_tdata[63:32]))
    else $error("left and right words differ");

  // A nonzero tone occupies the oscillator, so no new word is taken next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata != 16'd0) |=> !s_axis_tready)
    else $error("input taken while a tone word is in flight");

  // A silent tick leaves the oscillator free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata == 16'd0) |=> s_axis_tready)
    else $error("silent tick stalled the input");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("configuration port not ready");

endmodule

bind sine_tone_sample_generator stsg_checker u_stsg_checker (.*);
